// ----- src/bbm_pkg.sv -----
// Shared constants and types for the binary boundary marker.
`default_nettype none

package bbm_pkg;

    // Default line buffer depth (widest supported image row).
    localparam int MAX_WIDTH_DEF = 512;

    // Width used for size arithmetic (holds any clamped width or height).
    localparam int SIZE_W = 13;

    // Clamp limits and reset values of the size registers.
    localparam int SIZE_MIN     = 3;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int WIDTH_RESET  = 500;
    localparam int HEIGHT_RESET = 500;

    // Register field widths.
    localparam int CFG_WIDTH_W  = 10;
    localparam int CFG_HEIGHT_W = 13;

    // Result field widths.
    localparam int LABEL_W = 2;
    localparam int PIX_X_W = 9;
    localparam int PIX_Y_W = 12;

    // Configuration port geometry and register byte addresses.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] ADDR_IMAGE_WIDTH  = 3'd0;
    localparam logic [APB_ADDR_W-1:0] ADDR_IMAGE_HEIGHT = 3'd4;

    // Pixel labels.
    localparam logic [LABEL_W-1:0] LABEL_OUTSIDE  = 2'd0;
    localparam logic [LABEL_W-1:0] LABEL_INTERIOR = 2'd1;
    localparam logic [LABEL_W-1:0] LABEL_BOUNDARY = 2'd2;

    // One line buffer word: the same column of the two rows above the input row.
    typedef struct packed {
        logic upper;
        logic middle;
    } t_line_bits;

endpackage

`default_nettype wire

// ----- src/binary_boundary_marker_unit.sv -----
// Top level of the binary boundary marker: 3x3 boundary labelling of a raster bit stream.
//
//  Channel   | Direction | Signals                          | Contents
//  ----------+-----------+----------------------------------+-----------------------------
//  s_axis    | in        | tvalid tready tdata[7:0]         | member pixel bit
//  m_axis    | out       | tvalid tready tdata[23:0] tlast  | label, x, y; tlast frame end
//  apb       | in        | psel penable pwrite paddr pwdata | image width and height
//
// One pixel is accepted per clock while the buffer is not clearing and the output is not
// stalled. A pixel passes an input stage, where its line buffer column is read, and a
// result stage, where its window is labelled and registered. The line buffer memory has
// one read and one write port, which sets the rate at one pixel per cycle. After reset
// every buffer entry is cleared before the first pixel is taken. A stalled output holds
// its result while one further pixel is still taken into the input stage.
`default_nettype none

module binary_boundary_marker_unit #(
    parameter int MAX_WIDTH = bbm_pkg::MAX_WIDTH_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // Input pixel stream.
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire  [7:0]                       s_axis_tdata,   // [0] member, [7:1] zero
    // Output label stream.
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    output logic [23:0]                      m_axis_tdata,   // [1:0] label, [10:2] pixel_x,
                                                             // [22:11] pixel_y, [23] zero
    output logic                             m_axis_tlast,   // frame_end
    // Configuration port.
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [bbm_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire  [bbm_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [bbm_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int SW = bbm_pkg::SIZE_W;
    localparam int YW = bbm_pkg::PIX_Y_W;

    // Configuration registers.
    logic [bbm_pkg::CFG_WIDTH_W-1:0]  r_img_width;
    logic [bbm_pkg::CFG_HEIGHT_W-1:0] r_img_height;
    logic                             cfg_wr;

    // Effective sizes.
    logic [SW-1:0] w_eff;
    logic [SW-1:0] h_eff;
    logic [SW-1:0] w_last;
    logic [SW-1:0] h_last;

    // Position of the next input pixel.
    logic [XW-1:0] r_col;
    logic [YW-1:0] r_row;

    // Decode of the pixel being accepted.
    logic          in_xfer;
    logic [SW-1:0] x_ext;
    logic          row_end;
    logic          frame_last;
    logic          emit;
    logic [SW-1:0] cx;
    logic [YW-1:0] cy;
    logic          border;

    // Input stage.
    logic                           r_s1_valid;
    logic                           r_s1_member;
    logic [XW-1:0]                  r_s1_addr;
    logic                           r_s1_emit;
    logic                           r_s1_border;
    logic [bbm_pkg::PIX_X_W-1:0]    r_s1_x;
    logic [YW-1:0]                  r_s1_y;
    logic                           r_s1_last;
    logic                           s1_adv;

    // Line buffer port signals.
    bbm_pkg::t_line_bits rd_bits;
    bbm_pkg::t_line_bits wr_bits;
    logic                mem_busy;

    // Window and label.
    logic [8:0]                      r_window;
    logic [8:0]                      n_window;
    logic [bbm_pkg::LABEL_W-1:0]     label;

    // Result register.
    logic                            r_out_valid;
    logic [bbm_pkg::LABEL_W-1:0]     r_out_label;
    logic [bbm_pkg::PIX_X_W-1:0]     r_out_x;
    logic [YW-1:0]                   r_out_y;
    logic                            r_out_last;

    // Configuration writes and reads.
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_width  <= bbm_pkg::CFG_WIDTH_W'(bbm_pkg::WIDTH_RESET);
            r_img_height <= bbm_pkg::CFG_HEIGHT_W'(bbm_pkg::HEIGHT_RESET);
        end else if (cfg_wr) begin
            if (paddr == bbm_pkg::ADDR_IMAGE_WIDTH) begin
                r_img_width <= pwdata[bbm_pkg::CFG_WIDTH_W-1:0];
            end
            if (paddr == bbm_pkg::ADDR_IMAGE_HEIGHT) begin
                r_img_height <= pwdata[bbm_pkg::CFG_HEIGHT_W-1:0];
            end
        end
    end

    always_comb begin
        case (paddr)
            bbm_pkg::ADDR_IMAGE_WIDTH:  prdata = bbm_pkg::APB_DATA_W'(r_img_width);
            bbm_pkg::ADDR_IMAGE_HEIGHT: prdata = bbm_pkg::APB_DATA_W'(r_img_height);
            default:                    prdata = '0;
        endcase
    end

    // Clamp the programmed sizes to the supported range.
    always_comb begin
        if (SW'(r_img_width) < SW'(bbm_pkg::SIZE_MIN)) begin
            w_eff = SW'(bbm_pkg::SIZE_MIN);
        end else if (SW'(r_img_width) > SW'(MAX_WIDTH)) begin
            w_eff = SW'(MAX_WIDTH);
        end else begin
            w_eff = SW'(r_img_width);
        end
        if (r_img_height < SW'(bbm_pkg::SIZE_MIN)) begin
            h_eff = SW'(bbm_pkg::SIZE_MIN);
        end else if (r_img_height > SW'(bbm_pkg::HEIGHT_LIMIT)) begin
            h_eff = SW'(bbm_pkg::HEIGHT_LIMIT);
        end else begin
            h_eff = r_img_height;
        end
    end

    assign w_last = w_eff - 1'b1;
    assign h_last = h_eff - 1'b1;

    // Handshake: the input stage frees up when its pixel moves on.
    assign s1_adv        = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !mem_busy && (!r_s1_valid || s1_adv);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // Position decode for the pixel being accepted; the labelled pixel is one row and
    // one column behind it, wrapping to the end of the row before at column zero.
    always_comb begin
        x_ext      = SW'(r_col);
        row_end    = (x_ext >= w_last);
        frame_last = row_end && (SW'(r_row) >= h_last);
        emit       = (r_row >= YW'(2)) || ((r_row == YW'(1)) && (r_col != '0));
        if (r_col == '0) begin
            cx = w_last;
            cy = r_row - YW'(2);
        end else begin
            cx = x_ext - 1'b1;
            cy = r_row - YW'(1);
        end
        border = (cx == '0) || (cx >= w_last) || (cy == '0) || (SW'(cy) >= h_last);
    end

    // Raster counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_xfer) begin
            if (row_end) begin
                r_col <= '0;
                r_row <= frame_last ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // Input stage registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_member <= s_axis_tdata[0];
            r_s1_addr   <= r_col;
            r_s1_emit   <= emit;
            r_s1_border <= border;
            r_s1_x      <= cx[bbm_pkg::PIX_X_W-1:0];
            r_s1_y      <= cy;
            r_s1_last   <= frame_last;
        end
    end

    // Line buffers: the column read at transfer shifts down one row and takes the new bit.
    assign wr_bits.upper  = rd_bits.middle;
    assign wr_bits.middle = r_s1_member;

    bbm_line_mem #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_xfer),
        .i_rd_addr (r_col),
        .o_rd_data (rd_bits),
        .i_wr_en   (r_s1_valid),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (wr_bits),
        .o_busy    (mem_busy)
    );

    // 3x3 window, newest column in the low bits, top row in the high bit of each column.
    assign n_window = {r_window[5:0], rd_bits.upper, rd_bits.middle, r_s1_member};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
        end else if (s1_adv) begin
            r_window <= n_window;
        end
    end

    // Label of the window center.
    always_comb begin
        if (!n_window[4]) begin
            label = bbm_pkg::LABEL_OUTSIDE;
        end else if (r_s1_border) begin
            label = bbm_pkg::LABEL_INTERIOR;
        end else if ((n_window | 9'h010) != 9'h1FF) begin
            label = bbm_pkg::LABEL_BOUNDARY;
        end else begin
            label = bbm_pkg::LABEL_INTERIOR;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_emit;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_label <= label;
            r_out_x     <= r_s1_x;
            r_out_y     <= r_s1_y;
            r_out_last  <= r_s1_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_y, r_out_x, r_out_label};
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

// ----- src/bbm_line_mem.sv -----
// Two-row line buffer memory with a clearing sweep after reset.
`default_nettype none

module bbm_line_mem #(
    parameter int MAX_WIDTH = bbm_pkg::MAX_WIDTH_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_rd_en,
    input  wire [$clog2(MAX_WIDTH)-1:0]  i_rd_addr,
    output bbm_pkg::t_line_bits          o_rd_data,
    input  wire                          i_wr_en,
    input  wire [$clog2(MAX_WIDTH)-1:0]  i_wr_addr,
    input  wire bbm_pkg::t_line_bits     i_wr_data,
    output logic                         o_busy
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_WIDTH - 1);

    bbm_pkg::t_line_bits r_mem [MAX_WIDTH];
    bbm_pkg::t_line_bits r_rd_data;
    logic                r_clr_busy;
    logic [AW-1:0]       r_clr_addr;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    bbm_pkg::t_line_bits wr_data;

    // Clearing sweep: one entry per cycle from address zero up to the last entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == LAST_ADDR) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // The sweep owns the write port until it finishes.
    always_comb begin
        if (r_clr_busy) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else begin
            wr_en   = i_wr_en;
            wr_addr = i_wr_addr;
            wr_data = i_wr_data;
        end
    end

    // Memory write and registered read.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_clr_busy;

endmodule

`default_nettype wire

// ----- dv/tb_binary_boundary_marker_unit.sv -----
// Self-checking testbench for the binary boundary marker: directed and random stream traffic against a predictor.
`timescale 1ns / 100ps

module tb_binary_boundary_marker_unit;

    // Run length and timing limits.
    localparam int ITEM_TARGET     = 1700;
    localparam int DRAIN_PAUSE     = 8;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int QUIET_LIMIT     = 4000;
    localparam int PRINT_CAP       = 40;

    // Receiver behavior between phases.
    typedef enum logic [1:0] {
        SINK_ALWAYS,
        SINK_RANDOM,
        SINK_RUNS
    } t_sink_mode;

    // One labelled pixel as it leaves the block.
    typedef struct packed {
        logic [bbm_pkg::LABEL_W-1:0] label;
        logic [bbm_pkg::PIX_X_W-1:0] pixel_x;
        logic [bbm_pkg::PIX_Y_W-1:0] pixel_y;
        logic                        frame_end;
    } t_pixel_label;

    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [7:0]                     s_axis_tdata  = '0;  // [0] member, [7:1] zero
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [23:0]                    m_axis_tdata;  // [1:0] label, [10:2] x, [22:11] y, [23] zero
    logic                           m_axis_tlast;  // frame_end
    logic                           psel          = 1'b0;
    logic                           penable       = 1'b0;
    logic                           pwrite        = 1'b0;
    logic [bbm_pkg::APB_ADDR_W-1:0] paddr         = '0;
    logic [bbm_pkg::APB_DATA_W-1:0] pwdata        = '0;
    logic [bbm_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    // Traffic shaping shared by the sender and the receiver.
    t_sink_mode  sink_mode        = SINK_ALWAYS;
    logic        hold_off_pending = 1'b0;
    logic        sender_bursty    = 1'b0;
    int unsigned burst_left       = 0;
    int unsigned pixels_sent      = 0;
    int unsigned error_count      = 0;

    // Predictor state: size registers, line buffers, window and raster position.
    logic [bbm_pkg::CFG_WIDTH_W-1:0]  width_reg  =
        bbm_pkg::CFG_WIDTH_W'(bbm_pkg::WIDTH_RESET);
    logic [bbm_pkg::CFG_HEIGHT_W-1:0] height_reg =
        bbm_pkg::CFG_HEIGHT_W'(bbm_pkg::HEIGHT_RESET);
    logic                             row_above2 [bbm_pkg::MAX_WIDTH_DEF];
    logic                             row_above1 [bbm_pkg::MAX_WIDTH_DEF];
    logic [8:0]                       window     = '0;
    logic [bbm_pkg::PIX_X_W-1:0]      col_pos    = '0;
    logic [bbm_pkg::PIX_Y_W-1:0]      row_pos    = '0;
    t_pixel_label                     pending_labels [$];

    binary_boundary_marker_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Clock.
    always #1 i_clk = ~i_clk;

    // Mismatch reporting, with the printout capped.
    task automatic report_mismatch(input string what);
        if (error_count < PRINT_CAP) begin
            $display("ERROR at %0t ns: %s", $time, what);
        end
        error_count++;
    endtask

    function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
        if (v < bbm_pkg::SIZE_MIN) begin
            return bbm_pkg::SIZE_MIN;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    // Advance the predictor by one pixel and queue the label it releases, if any.
    task automatic predict_pixel_label(input logic member);
        int unsigned  w;
        int unsigned  h;
        int unsigned  x;
        int unsigned  y;
        int unsigned  cx;
        int unsigned  cy;
        logic         row_end;
        logic         frame_last;
        t_pixel_label lbl;
        w = clamp_size(width_reg, bbm_pkg::MAX_WIDTH_DEF);
        h = clamp_size(height_reg, bbm_pkg::HEIGHT_LIMIT);
        x = col_pos;
        y = row_pos;
        window = {window[5:0], row_above2[x], row_above1[x], member};
        row_above2[x] = row_above1[x];
        row_above1[x] = member;
        row_end    = (x >= w - 1);
        frame_last = row_end && (y >= h - 1);
        if (y >= 2 || (y == 1 && x >= 1)) begin
            // The window center lags one row and one pixel behind the input.
            if (x == 0) begin
                cx = w - 1;
                cy = y - 2;
            end else begin
                cx = x - 1;
                cy = y - 1;
            end
            if (!window[4]) begin
                lbl.label = bbm_pkg::LABEL_OUTSIDE;
            end else if (cx == 0 || cx >= w - 1 || cy == 0 || cy >= h - 1) begin
                lbl.label = bbm_pkg::LABEL_INTERIOR;
            end else if ((window | 9'h010) != 9'h1FF) begin
                lbl.label = bbm_pkg::LABEL_BOUNDARY;
            end else begin
                lbl.label = bbm_pkg::LABEL_INTERIOR;
            end
            lbl.pixel_x   = bbm_pkg::PIX_X_W'(cx);
            lbl.pixel_y   = bbm_pkg::PIX_Y_W'(cy);
            lbl.frame_end = frame_last;
            pending_labels.push_back(lbl);
        end
        if (row_end) begin
            col_pos = '0;
            row_pos = frame_last ? '0 : bbm_pkg::PIX_Y_W'(y + 1);
        end else begin
            col_pos = bbm_pkg::PIX_X_W'(x + 1);
        end
    endtask

    // Offer one pixel, wait for its transfer, then predict.
    task automatic send_pixel(input logic member);
        if (sender_bursty && burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, member};
        do @(posedge i_clk); while (!s_axis_tready);
        if (burst_left != 0) begin
            burst_left--;
        end
        pixels_sent++;
        predict_pixel_label(member);
    endtask

    // Let every expected label arrive, then give the pipeline time to settle.
    task automatic wait_until_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_labels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_PAUSE) @(posedge i_clk);
    endtask

    // Register write followed by a read back of the stored value.
    task automatic write_register(input logic [bbm_pkg::APB_ADDR_W-1:0] addr,
                                  input logic [31:0] value, input logic [31:0] mask);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== (value & mask)) begin
            report_mismatch($sformatf("register %0d reads %0h, expected %0h",
                                      addr, prdata, value & mask));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Change the image size once the block is idle.
    task automatic set_image_size(input int unsigned width_val, input int unsigned height_val);
        wait_until_drained();
        write_register(bbm_pkg::ADDR_IMAGE_WIDTH, width_val,
                       (32'd1 << bbm_pkg::CFG_WIDTH_W) - 1);
        width_reg = bbm_pkg::CFG_WIDTH_W'(width_val);
        write_register(bbm_pkg::ADDR_IMAGE_HEIGHT, height_val,
                       (32'd1 << bbm_pkg::CFG_HEIGHT_W) - 1);
        height_reg = bbm_pkg::CFG_HEIGHT_W'(height_val);
    endtask

    // Receiver: ready pattern of its own, plus a long hold-off on request.
    initial begin : label_sink
        logic        level;
        int unsigned run_left;
        level    = 1'b1;
        run_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off_pending) begin
                hold_off_pending <= 1'b0;
                m_axis_tready    <= 1'b0;
                for (int n = 0; n < HOLD_OFF_CYCLES; n++) @(posedge i_clk);
            end
            case (sink_mode)
                SINK_ALWAYS: begin
                    m_axis_tready <= 1'b1;
                end
                SINK_RANDOM: begin
                    m_axis_tready <= ($urandom_range(0, 99) >= 30);
                end
                default: begin
                    if (run_left == 0) begin
                        level    = !level;
                        run_left = level ? $urandom_range(1, 12) : $urandom_range(1, 8);
                    end
                    run_left--;
                    m_axis_tready <= level;
                end
            endcase
        end
    end

    // Compare each label transfer with the oldest prediction.
    always @(posedge i_clk) begin : label_check
        t_pixel_label got;
        t_pixel_label want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[1:0], m_axis_tdata[10:2], m_axis_tdata[22:11], m_axis_tlast};
            if (pending_labels.size() == 0) begin
                report_mismatch($sformatf("unexpected label %0d at (%0d,%0d)",
                                          got.label, got.pixel_x, got.pixel_y));
            end else begin
                want = pending_labels.pop_front();
                if (got.label !== want.label) begin
                    report_mismatch($sformatf("label %0d, expected %0d at (%0d,%0d)",
                                              got.label, want.label, want.pixel_x,
                                              want.pixel_y));
                end
                if (got.pixel_x !== want.pixel_x) begin
                    report_mismatch($sformatf("pixel_x %0d, expected %0d",
                                              got.pixel_x, want.pixel_x));
                end
                if (got.pixel_y !== want.pixel_y) begin
                    report_mismatch($sformatf("pixel_y %0d, expected %0d",
                                              got.pixel_y, want.pixel_y));
                end
                if (got.frame_end !== want.frame_end) begin
                    report_mismatch($sformatf("frame_end %0d, expected %0d at (%0d,%0d)",
                                              got.frame_end, want.frame_end, want.pixel_x,
                                              want.pixel_y));
                end
            end
        end
    end

    // End the run when no transfer happens for too long.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("** binary_boundary_marker_unit: FAILED **");
        $finish;
    end

    // Both registers across their extremes, ending on the smallest clamped frame.
    task automatic test_register_access();
        set_image_size(1023, 8191);
        set_image_size(0, 0);
        set_image_size(512, 4096);
        set_image_size(2, 1);
    endtask

    // Two 3x3 frames: a solid one and one with a clear corner beside the center.
    task automatic test_smallest_frames();
        logic [8:0] solid;
        logic [8:0] notched;
        solid   = 9'h1FF;
        notched = 9'h1FE;
        sink_mode     = SINK_ALWAYS;
        sender_bursty = 1'b0;
        for (int i = 0; i < 9; i++) send_pixel(solid[i]);
        for (int i = 0; i < 9; i++) send_pixel(notched[i]);
        wait_until_drained();
    endtask

    // Clamped widest row: reaches the last column and leaves the frame open.
    task automatic test_full_width_rows();
        set_image_size(1023, 8191);
        sink_mode     = SINK_RANDOM;
        sender_bursty = 1'b1;
        for (int i = 0; i < 2 * bbm_pkg::MAX_WIDTH_DEF + 16; i++) begin
            send_pixel($urandom_range(0, 99) < 70);
        end
    endtask

    // Shrink the frame while the counters sit past the new last column and on the new last row.
    task automatic test_resize_mid_frame();
        set_image_size(5, 3);
        sink_mode     = SINK_RUNS;
        sender_bursty = 1'b0;
        for (int i = 0; i < 40; i++) send_pixel($urandom_range(0, 99) < 85);
        wait_until_drained();
    endtask

    // Receiver holds off for a long stretch while pixels keep coming.
    task automatic test_input_backpressure();
        set_image_size(6, 5);
        sink_mode        = SINK_ALWAYS;
        sender_bursty    = 1'b0;
        hold_off_pending <= 1'b1;
        for (int i = 0; i < 90; i++) send_pixel($urandom_range(0, 99) < 90);
        wait_until_drained();
    endtask

    // Phases of random sizes, densities and traffic shapes.
    task automatic test_random_frames();
        int unsigned w;
        int unsigned h;
        int unsigned count;
        int unsigned density;
        while (pixels_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 1) == 1) begin
                case ($urandom_range(0, 9))
                    0:       w = $urandom_range(0, 2);
                    1:       w = $urandom_range(513, 1023);
                    2:       w = $urandom_range(13, 64);
                    default: w = $urandom_range(3, 12);
                endcase
                case ($urandom_range(0, 7))
                    0:       h = $urandom_range(0, 2);
                    1:       h = $urandom_range(4097, 8191);
                    default: h = $urandom_range(3, 8);
                endcase
                set_image_size(w, h);
            end
            case ($urandom_range(0, 3))
                0:       density = 15;
                1:       density = 50;
                2:       density = 85;
                default: density = 100;
            endcase
            sink_mode     = t_sink_mode'($urandom_range(0, 2));
            sender_bursty = $urandom_range(0, 2) != 0;
            count = (clamp_size(width_reg, bbm_pkg::MAX_WIDTH_DEF) > 64)
                    ? $urandom_range(30, 150) : $urandom_range(20, 120);
            for (int i = 0; i < count; i++) send_pixel($urandom_range(0, 99) < density);
        end
    endtask

    // Test sequence.
    initial begin
        for (int i = 0; i < bbm_pkg::MAX_WIDTH_DEF; i++) begin
            row_above2[i] = 1'b0;
            row_above1[i] = 1'b0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_register_access();
        test_smallest_frames();
        test_full_width_rows();
        test_resize_mid_frame();
        test_input_backpressure();
        test_random_frames();
        wait_until_drained();
        if (error_count == 0) begin
            $display("** binary_boundary_marker_unit: PASSED **");
        end else begin
            $display("** binary_boundary_marker_unit: FAILED **");
        end
        $finish;
    end

endmodule
